@@ hdl/gbd_pkg.sv @@
// Package for the binary GNSS packet deframer.
// Holds frame constants, end status codes and the parser result type.
// No dependencies.
package gbd_pkg;

    // Frame limits
    localparam int unsigned MAX_FRAME_BYTES_DEF = 255;
    localparam int unsigned PAYLOAD_OFFSET      = 6;
    localparam int unsigned MIN_LENGTH          = 9;

    // Framing bytes
    localparam logic [7:0] PRE_FIRST  = 8'h04;
    localparam logic [7:0] PRE_SECOND = 8'h24;
    localparam logic [7:0] END_FIRST  = 8'h0D;
    localparam logic [7:0] END_SECOND = 8'h0A;
    localparam logic [7:0] BYTE_MAX   = 8'hFF;

    // Frame positions (0 means hunting for the preamble)
    localparam logic [8:0] POS_HUNT   = 9'd0;
    localparam logic [8:0] POS_LEN_LO = 9'd2;
    localparam logic [8:0] POS_LEN_HI = 9'd3;
    localparam logic [8:0] POS_CMD_LO = 9'd4;
    localparam logic [8:0] POS_CMD_HI = 9'd5;
    localparam logic [9:0] POS_LIMIT  = 10'd511;

    // End status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CSUM   = 2'd1;
    localparam logic [1:0] ST_OVFL   = 2'd2;
    localparam logic [1:0] ST_BADLEN = 2'd3;

    // One result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_strobe;
        logic [7:0]  payload_index;
        logic        frame_end;
        logic [1:0]  end_status;
        logic [15:0] frame_command;
        logic [7:0]  payload_length;
    } t_result;

endpackage

@@ hdl/gbd_parser.sv @@
// Frame parser: holds the deframer state and computes one result per byte.
// Depends on gbd_pkg.
module gbd_parser #(
    parameter int unsigned MAX_FRAME_BYTES = gbd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output gbd_pkg::t_result o_result
);
    import gbd_pkg::*;

    localparam logic [16:0] LP_MAX = 17'(MAX_FRAME_BYTES);

    logic [7:0]  r_prev,  n_prev;
    logic [8:0]  r_pos,   n_pos;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [7:0]  r_decl,  n_decl;
    logic [15:0] r_cmd,   n_cmd;
    logic [7:0]  r_par,   n_par;
    logic [7:0]  r_chk,   n_chk;

    logic [15:0] total;
    logic [15:0] pl;
    logic [9:0]  pay_end;
    logic [9:0]  np;
    logic        ended;
    logic [1:0]  status;
    logic        strobe;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;
    logic [9:0]  pidx_full;

    assign total     = {i_byte, r_len_lo};
    assign pl        = total - 16'(MIN_LENGTH);
    assign pay_end   = 10'(PAYLOAD_OFFSET) + {2'b00, r_decl};
    assign np        = {1'b0, r_pos} + 10'd1;
    assign pidx_full = {1'b0, r_pos} - 10'(PAYLOAD_OFFSET);

    // Next state and result for the byte at hand
    always_comb begin
        n_prev   = i_byte;
        n_pos    = r_pos;
        n_len_lo = r_len_lo;
        n_decl   = r_decl;
        n_cmd    = r_cmd;
        n_par    = r_par;
        n_chk    = r_chk;
        ended    = 1'b0;
        status   = ST_OK;
        strobe   = 1'b0;
        pbyte    = 8'd0;
        pidx     = 8'd0;
        if (r_pos == POS_HUNT) begin
            if (i_byte == PRE_SECOND && r_prev == PRE_FIRST) begin
                n_pos    = POS_LEN_LO;
                n_len_lo = 8'd0;
                n_decl   = 8'd0;
                n_cmd    = 16'd0;
                n_par    = 8'd0;
                n_chk    = 8'd0;
            end
        end else begin
            priority if (r_pos == POS_LEN_LO) begin
                n_len_lo = i_byte;
                n_par    = r_par ^ i_byte;
            end else if (r_pos == POS_LEN_HI) begin
                n_par = r_par ^ i_byte;
                if (total < 16'(MIN_LENGTH)) begin
                    n_decl = 8'd0;
                    ended  = 1'b1;
                    status = ST_BADLEN;
                end else begin
                    n_decl = (pl > 16'(BYTE_MAX)) ? BYTE_MAX : pl[7:0];
                end
            end else if (r_pos == POS_CMD_LO) begin
                n_cmd = {r_cmd[15:8], i_byte};
                n_par = r_par ^ i_byte;
            end else if (r_pos == POS_CMD_HI) begin
                n_cmd = {i_byte, r_cmd[7:0]};
                n_par = r_par ^ i_byte;
            end else if ({1'b0, r_pos} < pay_end) begin
                strobe = 1'b1;
                pbyte  = i_byte;
                pidx   = pidx_full[7:0];
                n_par  = r_par ^ i_byte;
            end else if ({1'b0, r_pos} == pay_end) begin
                n_chk = i_byte;
            end else if (i_byte == END_SECOND && r_prev == END_FIRST) begin
                ended  = 1'b1;
                status = (r_chk == r_par) ? ST_OK : ST_CSUM;
            end else begin
                n_chk = r_chk;
            end

            // Advance position, return to hunting at a frame end, or abort on overflow
            if (ended) begin
                n_pos = POS_HUNT;
            end else if ({7'd0, np} > LP_MAX || np > POS_LIMIT) begin
                ended  = 1'b1;
                status = ST_OVFL;
                n_pos  = POS_HUNT;
            end else begin
                n_pos = np[8:0];
            end
        end
    end

    assign o_result.payload_byte   = pbyte;
    assign o_result.payload_strobe = strobe;
    assign o_result.payload_index  = pidx;
    assign o_result.frame_end      = ended;
    assign o_result.end_status     = status;
    assign o_result.frame_command  = n_cmd;
    assign o_result.payload_length = n_decl;

    // State registers, updated once per byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 8'd0;
            r_pos    <= POS_HUNT;
            r_len_lo <= 8'd0;
            r_decl   <= 8'd0;
            r_cmd    <= 16'd0;
            r_par    <= 8'd0;
            r_chk    <= 8'd0;
        end else if (i_step) begin
            r_prev   <= n_prev;
            r_pos    <= n_pos;
            r_len_lo <= n_len_lo;
            r_decl   <= n_decl;
            r_cmd    <= n_cmd;
            r_par    <= n_par;
            r_chk    <= n_chk;
        end
    end

endmodule

@@ hdl/binary_gnss_packet_deframer_unit.sv @@
// Top level of the binary GNSS packet deframer: input register, parser, result register.
// Depends on gbd_pkg and gbd_parser.
//
//   channel | direction | handshake                  | payload
//   in      | in        | i_in_valid / o_in_stall    | i_rx_byte
//   out     | out       | o_out_valid / i_out_stall  | o_payload_byte .. o_payload_length
//
// One byte per cycle sustained while the output is not stalled; a byte's result is registered
// as it leaves the input register. The running XOR and position counter are computed between
// the input and result registers. Synchronous active-low reset returns the parser to preamble
// hunting. While the result is stalled, one further byte is held in the input register.
module binary_gnss_packet_deframer_unit #(
    parameter int unsigned MAX_FRAME_BYTES = gbd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_strobe,
    output logic [7:0]  o_payload_index,
    output logic        o_frame_end,
    output logic [1:0]  o_end_status,
    output logic [15:0] o_frame_command,
    output logic [7:0]  o_payload_length
);
    import gbd_pkg::*;

    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    step;

    // Move the held byte through the parser when the result slot is free
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    gbd_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_result(result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_strobe = r_out.payload_strobe;
    assign o_payload_index  = r_out.payload_index;
    assign o_frame_end      = r_out.frame_end;
    assign o_end_status     = r_out.end_status;
    assign o_frame_command  = r_out.frame_command;
    assign o_payload_length = r_out.payload_length;

    // A payload byte can only end its frame by overflow
    a_strobe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_strobe && o_frame_end |-> o_end_status == ST_OVFL)
        else $error("payload byte ended frame with non-overflow status");

    // Non-payload results carry zero byte and index
    a_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_payload_strobe |-> o_payload_byte == 8'd0 && o_payload_index == 8'd0)
        else $error("payload fields set without strobe");

    // A bad length reports zero payload length
    a_badlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end && o_end_status == ST_BADLEN |-> o_payload_length == 8'd0)
        else $error("bad length with nonzero payload length");

    // Stall only while a byte is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with free pipeline");

endmodule
